FILE: hw/rtl/rlrb_pkg.sv
// Shared constants, types and helpers for the receive line ring buffer.
// Used by the front end, command queue, back end and top level.
package rlrb_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 2);

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RECEIVE_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_CHAR_A  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_CHAR_B  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_CHAR_C  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_CHAR_D  = 3'd4;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_WRITE,
    CMD_LINE
  } cmd_op_t;

  // ECHO: one result carrying data as ignored_char.
  // WRITE: store data at ptr, one plain result.
  // LINE: emit count bytes starting at ptr.
  typedef struct packed {
    cmd_op_t          op;
    logic [PTR_W-1:0] ptr;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ignored_char;
    logic       line_found;
    logic [7:0] line_byte;
    logic       last;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/rlrb_front.sv
// Front end: configuration registers, item classification and ring pointers.
// Depends on rlrb_pkg; feeds commands to rlrb_cmd_queue.
module rlrb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            action,
  input  logic [7:0]                      rx_byte,
  input  logic                            cmdq_full,
  output logic                            cmd_push,
  output rlrb_pkg::cmd_t                  cmd,
  input  logic                            cfg_write,
  input  logic [rlrb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);

  logic                         receive_enable;
  logic [7:0]                   ignore_char [4];
  logic [rlrb_pkg::PTR_W-1:0]   write_pos, write_pos_next;
  logic [rlrb_pkg::PTR_W-1:0]   start_pos, start_pos_next;
  logic                         newline_valid, newline_valid_next;
  logic [rlrb_pkg::PTR_W-1:0]   newline_pos, newline_pos_next;
  logic                         accept;
  logic                         match;
  logic [rlrb_pkg::PTR_W:0]     span;

  assign accept   = push && !cmdq_full;
  assign cmd_push = accept;

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (ignore_char[i] != 8'h00 && ignore_char[i] == rx_byte) begin
        match = 1'b1;
      end
    end
  end

  // distance from start to newline, wrapped
  always_comb begin
    if (newline_pos >= start_pos) begin
      span = {1'b0, newline_pos} - {1'b0, start_pos};
    end else begin
      span = {1'b0, newline_pos} + (rlrb_pkg::PTR_W+1)'(rlrb_pkg::RING_DEPTH)
             - {1'b0, start_pos};
    end
  end

  always_comb begin
    write_pos_next     = write_pos;
    start_pos_next     = start_pos;
    newline_valid_next = newline_valid;
    newline_pos_next   = newline_pos;
    cmd.op    = rlrb_pkg::CMD_ECHO;
    cmd.ptr   = write_pos;
    cmd.data  = 8'h00;
    cmd.count = rlrb_pkg::CNT_W'(1);
    if (!action) begin
      if (receive_enable && match) begin
        cmd.data = rx_byte;
      end else if (receive_enable) begin
        cmd.op   = rlrb_pkg::CMD_WRITE;
        cmd.data = rx_byte;
        if (rx_byte == rlrb_pkg::NEWLINE_CHAR) begin
          newline_valid_next = 1'b1;
          newline_pos_next   = write_pos;
        end
        write_pos_next = rlrb_pkg::ptr_inc(write_pos);
        // drop the mark once the writer laps it
        if (newline_valid_next && write_pos_next == newline_pos_next) begin
          newline_valid_next = 1'b0;
        end
        // ring full: give up the oldest byte
        if (write_pos_next == start_pos) begin
          start_pos_next = rlrb_pkg::ptr_inc(start_pos);
        end
      end
    end else if (newline_valid) begin
      cmd.op             = rlrb_pkg::CMD_LINE;
      cmd.ptr            = start_pos;
      cmd.count          = rlrb_pkg::CNT_W'(span) + rlrb_pkg::CNT_W'(1);
      newline_valid_next = 1'b0;
      start_pos_next     = rlrb_pkg::ptr_inc(newline_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= '0;
      start_pos     <= '0;
      newline_valid <= 1'b0;
      newline_pos   <= '0;
    end else if (accept) begin
      write_pos     <= write_pos_next;
      start_pos     <= start_pos_next;
      newline_valid <= newline_valid_next;
      newline_pos   <= newline_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_enable <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        ignore_char[i] <= 8'h00;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        rlrb_pkg::REG_RECEIVE_ENABLE: receive_enable <= cfg_data[0];
        rlrb_pkg::REG_IGNORE_CHAR_A:  ignore_char[0] <= cfg_data;
        rlrb_pkg::REG_IGNORE_CHAR_B:  ignore_char[1] <= cfg_data;
        rlrb_pkg::REG_IGNORE_CHAR_C:  ignore_char[2] <= cfg_data;
        rlrb_pkg::REG_IGNORE_CHAR_D:  ignore_char[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rlrb_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on rlrb_pkg for the command type and depth.
module rlrb_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rlrb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output rlrb_pkg::cmd_t head_cmd,
  output logic           empty
);

  rlrb_pkg::cmd_t                  entries [rlrb_pkg::CMDQ_DEPTH];
  logic [rlrb_pkg::CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [rlrb_pkg::CMDQ_CNT_W-1:0] count;
  logic                            do_push, do_pop;

  assign full     = (count == rlrb_pkg::CMDQ_CNT_W'(rlrb_pkg::CMDQ_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + rlrb_pkg::CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rlrb_pkg::CMDQ_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + rlrb_pkg::CMDQ_CNT_W'(1);
        2'b01:   count <= count - rlrb_pkg::CMDQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rlrb_back.sv
// Back end: ring memory, line read sequencer and result queue.
// Depends on rlrb_pkg; takes commands from rlrb_cmd_queue.
module rlrb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmdq_empty,
  input  rlrb_pkg::cmd_t head_cmd,
  output logic           cmdq_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     ignored_char,
  output logic           line_found,
  output logic [7:0]     line_byte,
  output logic           last
);

  logic [7:0]                      ring [rlrb_pkg::RING_DEPTH];
  logic [7:0]                      rd_data;

  logic                            in_line;
  logic [rlrb_pkg::PTR_W-1:0]      line_ptr;
  logic [rlrb_pkg::CNT_W-1:0]      remaining;

  logic                            s1_valid;
  logic                            s1_found;
  logic [7:0]                      s1_ign;
  logic                            s1_last;

  rlrb_pkg::result_t               outq [rlrb_pkg::OUTQ_DEPTH];
  logic [rlrb_pkg::OUTQ_PTR_W-1:0] oq_wr, oq_rd;
  logic [rlrb_pkg::OUTQ_CNT_W-1:0] oq_count;
  logic                            oq_pop;
  rlrb_pkg::result_t               oq_in;
  rlrb_pkg::result_t               oq_head;

  logic                            room;
  logic                            line_step;
  logic                            mem_we;

  // leave a slot for the result already in flight
  assign room = (oq_count + rlrb_pkg::OUTQ_CNT_W'(s1_valid))
                < rlrb_pkg::OUTQ_CNT_W'(rlrb_pkg::OUTQ_DEPTH);
  assign line_step = room && in_line;
  assign cmdq_pop  = room && !in_line && !cmdq_empty;
  assign mem_we    = cmdq_pop && (head_cmd.op == rlrb_pkg::CMD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[head_cmd.ptr] <= head_cmd.data;
    end
    rd_data <= ring[line_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_line  <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (line_step) begin
        s1_valid <= 1'b1;
        if (remaining == rlrb_pkg::CNT_W'(1)) begin
          in_line <= 1'b0;
        end
      end else if (cmdq_pop) begin
        case (head_cmd.op)
          rlrb_pkg::CMD_LINE: begin
            in_line  <= 1'b1;
            s1_valid <= 1'b0;
          end
          rlrb_pkg::CMD_WRITE: s1_valid <= 1'b1;
          rlrb_pkg::CMD_ECHO:  s1_valid <= 1'b1;
          default:             s1_valid <= 1'b1;
        endcase
      end else begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_step) begin
      line_ptr  <= rlrb_pkg::ptr_inc(line_ptr);
      remaining <= remaining - rlrb_pkg::CNT_W'(1);
      s1_found  <= 1'b1;
      s1_ign    <= 8'h00;
      s1_last   <= (remaining == rlrb_pkg::CNT_W'(1));
    end else if (cmdq_pop) begin
      s1_found <= 1'b0;
      s1_last  <= 1'b1;
      s1_ign   <= (head_cmd.op == rlrb_pkg::CMD_ECHO) ? head_cmd.data : 8'h00;
      if (head_cmd.op == rlrb_pkg::CMD_LINE) begin
        line_ptr  <= head_cmd.ptr;
        remaining <= head_cmd.count;
      end
    end
  end

  always_comb begin
    oq_in.ignored_char = s1_ign;
    oq_in.line_found   = s1_found;
    oq_in.line_byte    = s1_found ? rd_data : 8'h00;
    oq_in.last         = s1_last;
  end

  assign empty   = (oq_count == '0);
  assign oq_pop  = pop && !empty;
  assign oq_head = outq[oq_rd];

  assign ignored_char = oq_head.ignored_char;
  assign line_found   = oq_head.line_found;
  assign line_byte    = oq_head.line_byte;
  assign last         = oq_head.last;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      outq[oq_wr] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (s1_valid) begin
        oq_wr <= oq_wr + rlrb_pkg::OUTQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + rlrb_pkg::OUTQ_PTR_W'(1);
      end
      case ({s1_valid, oq_pop})
        2'b10:   oq_count <= oq_count + rlrb_pkg::OUTQ_CNT_W'(1);
        2'b01:   oq_count <= oq_count - rlrb_pkg::OUTQ_CNT_W'(1);
        default: oq_count <= oq_count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rx_line_ring_buffer.sv
// Top level of the receive line ring buffer: front end, command queue, back end.
// Depends on rlrb_pkg, rlrb_front, rlrb_cmd_queue and rlrb_back.
//
// The front end takes one item per cycle while the four-entry command queue
// has room: a received byte or a read request is classified and the ring
// pointers are updated at once. The back end owns the 64-byte ring memory and
// works through commands in order: a byte event or an empty read gives one
// result; a line read first loads the sequencer, then reads one byte per cycle
// from the memory's single read port while the result queue has room. A
// four-entry result queue lets the front keep accepting while results wait
// to be popped.
module rx_line_ring_buffer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            action,
  input  logic [7:0]                      rx_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      ignored_char,
  output logic                            line_found,
  output logic [7:0]                      line_byte,
  output logic                            last,
  input  logic                            cfg_write,
  input  logic [rlrb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);

  rlrb_pkg::cmd_t front_cmd;
  rlrb_pkg::cmd_t head_cmd;
  logic           cmd_push;
  logic           cmdq_full;
  logic           cmdq_empty;
  logic           cmdq_pop;

  assign full = cmdq_full;

  rlrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .action    (action),
    .rx_byte   (rx_byte),
    .cmdq_full (cmdq_full),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rlrb_cmd_queue u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .full     (cmdq_full),
    .pop      (cmdq_pop),
    .head_cmd (head_cmd),
    .empty    (cmdq_empty)
  );

  rlrb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmdq_empty   (cmdq_empty),
    .head_cmd     (head_cmd),
    .cmdq_pop     (cmdq_pop),
    .empty        (empty),
    .pop          (pop),
    .ignored_char (ignored_char),
    .line_found   (line_found),
    .line_byte    (line_byte),
    .last         (last)
  );

endmodule

FILE: sim/tb_top.sv
// Testbench for rx_line_ring_buffer: directed table, then random line traffic.
// Depends on rlrb_pkg and the rx_line_ring_buffer RTL; checks every result item against
// a cycle-free model of the ring, pointers and newline mark, or the table if typed.
module tb_top;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam logic [rlrb_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [rlrb_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 11;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_BYTE,
    ROW_READ
  } row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [rlrb_pkg::REG_IDX_W-1:0]     idx;
    logic [7:0]                         data;
    logic                               typed;
    rlrb_pkg::result_t                  res;
  } row_t;

  localparam rlrb_pkg::result_t PLAIN_DONE = '{8'h00, 1'b0, 8'h00, 1'b1};
  localparam rlrb_pkg::result_t NO_TYPED   = '0;

  localparam int NUM_ROWS = 26;
  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    // reception is off after reset, and no line is pending
    '{ROW_BYTE, '0, 8'h41, 1'b1, PLAIN_DONE},
    '{ROW_READ, '0, 8'h00, 1'b1, PLAIN_DONE},
    '{ROW_REG, rlrb_pkg::REG_RECEIVE_ENABLE, 8'h01, 1'b0, NO_TYPED},
    '{ROW_REG, rlrb_pkg::REG_IGNORE_CHAR_A, 8'hFF, 1'b0, NO_TYPED},
    '{ROW_REG, rlrb_pkg::REG_IGNORE_CHAR_B, 8'h7E, 1'b0, NO_TYPED},
    '{ROW_REG, rlrb_pkg::REG_IGNORE_CHAR_C, 8'h55, 1'b0, NO_TYPED},
    '{ROW_REG, rlrb_pkg::REG_IGNORE_CHAR_D, 8'h01, 1'b0, NO_TYPED},
    '{ROW_REG, REG_SPARE_HI, 8'hFF, 1'b0, NO_TYPED},
    '{ROW_REG, REG_SPARE_LO, 8'h00, 1'b0, NO_TYPED},
    // each ignore slot echoes its byte
    '{ROW_BYTE, '0, 8'hFF, 1'b1, '{8'hFF, 1'b0, 8'h00, 1'b1}},
    '{ROW_BYTE, '0, 8'h7E, 1'b1, '{8'h7E, 1'b0, 8'h00, 1'b1}},
    '{ROW_BYTE, '0, 8'h55, 1'b1, '{8'h55, 1'b0, 8'h00, 1'b1}},
    '{ROW_BYTE, '0, 8'h01, 1'b1, '{8'h01, 1'b0, 8'h00, 1'b1}},
    // zero byte is stored even though all four slots are in use
    '{ROW_BYTE, '0, 8'h00, 1'b1, PLAIN_DONE},
    '{ROW_BYTE, '0, 8'h80, 1'b1, PLAIN_DONE},
    '{ROW_BYTE, '0, rlrb_pkg::NEWLINE_CHAR, 1'b1, PLAIN_DONE},
    '{ROW_READ, '0, 8'hFF, 1'b0, NO_TYPED},
    '{ROW_READ, '0, 8'h00, 1'b1, PLAIN_DONE},
    // two lines and a tail: only the newest newline is tracked
    '{ROW_BYTE, '0, 8'h61, 1'b0, NO_TYPED},
    '{ROW_BYTE, '0, rlrb_pkg::NEWLINE_CHAR, 1'b0, NO_TYPED},
    '{ROW_BYTE, '0, 8'h62, 1'b0, NO_TYPED},
    '{ROW_BYTE, '0, rlrb_pkg::NEWLINE_CHAR, 1'b0, NO_TYPED},
    '{ROW_BYTE, '0, 8'h63, 1'b0, NO_TYPED},
    '{ROW_READ, '0, 8'h5A, 1'b0, NO_TYPED},
    '{ROW_BYTE, '0, rlrb_pkg::NEWLINE_CHAR, 1'b0, NO_TYPED},
    '{ROW_READ, '0, 8'hA5, 1'b0, NO_TYPED}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  logic                           action = 1'b0;
  logic [7:0]                     rx_byte = 8'h00;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [7:0]                     ignored_char;
  logic                           line_found;
  logic [7:0]                     line_byte;
  logic                           last;
  logic                           cfg_write = 1'b0;
  logic [rlrb_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = 8'h00;

  // ring model
  logic [7:0]                 ring_mem [rlrb_pkg::RING_DEPTH];
  logic [rlrb_pkg::PTR_W-1:0] wr_ptr;
  logic [rlrb_pkg::PTR_W-1:0] head_ptr;
  logic [rlrb_pkg::PTR_W-1:0] nl_ptr;
  logic                       nl_pending;
  logic                       rx_en;
  logic [7:0]                 ign_chars [4];

  rlrb_pkg::result_t rx_results_q [$];
  rlrb_pkg::result_t head_res;
  int                mismatch_count = 0;
  bit                idle_on = 1'b1;

  rx_line_ring_buffer DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .ignored_char (ignored_char),
    .line_found   (line_found),
    .line_byte    (line_byte),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [rlrb_pkg::PTR_W-1:0] next_ptr(
    input logic [rlrb_pkg::PTR_W-1:0] p);
    return (int'(p) == rlrb_pkg::RING_DEPTH - 1) ? '0 : p + rlrb_pkg::PTR_W'(1);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) == 0) begin
      return ign_chars[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Update the ring model with one accepted item and queue the result items it causes.
  task automatic apply_rx_item(input logic act, input logic [7:0] b);
    int                         cnt;
    int                         k;
    bit                         hit;
    logic [rlrb_pkg::PTR_W-1:0] p;
    rlrb_pkg::result_t          r;
    r = '0;
    r.last = 1'b1;
    if (act == ACT_BYTE) begin
      hit = 1'b0;
      if (rx_en) begin
        foreach (ign_chars[i]) begin
          if (ign_chars[i] != 8'h00 && ign_chars[i] == b) hit = 1'b1;
        end
        if (hit) begin
          r.ignored_char = b;
        end else begin
          ring_mem[wr_ptr] = b;
          if (b == rlrb_pkg::NEWLINE_CHAR) begin
            nl_pending = 1'b1;
            nl_ptr = wr_ptr;
          end
          wr_ptr = next_ptr(wr_ptr);
          if (nl_pending && wr_ptr == nl_ptr) nl_pending = 1'b0;
          // give up the oldest byte when the ring wraps onto it
          if (wr_ptr == head_ptr) head_ptr = next_ptr(head_ptr);
        end
      end
      rx_results_q.push_back(r);
    end else if (!nl_pending) begin
      rx_results_q.push_back(r);
    end else begin
      cnt = (int'(nl_ptr) + rlrb_pkg::RING_DEPTH - int'(head_ptr)) % rlrb_pkg::RING_DEPTH
            + 1;
      p = head_ptr;
      for (k = 0; k < cnt; k++) begin
        r.line_found = 1'b1;
        r.line_byte  = ring_mem[p];
        r.last       = (k == cnt - 1);
        rx_results_q.push_back(r);
        p = next_ptr(p);
      end
      nl_pending = 1'b0;
      head_ptr = next_ptr(nl_ptr);
    end
  endtask

  task automatic send_item(input logic act, input logic [7:0] b, input bit typed,
                           input rlrb_pkg::result_t want);
    int n0;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    action  <= act;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    n0 = rx_results_q.size();
    apply_rx_item(act, b);
    // typed rows keep the model in step but check against the table
    if (typed) begin
      while (rx_results_q.size() > n0) void'(rx_results_q.pop_back());
      rx_results_q.push_back(want);
    end
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (rx_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rlrb_pkg::REG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      rlrb_pkg::REG_RECEIVE_ENABLE: rx_en = data[0];
      rlrb_pkg::REG_IGNORE_CHAR_A:  ign_chars[0] = data;
      rlrb_pkg::REG_IGNORE_CHAR_B:  ign_chars[1] = data;
      rlrb_pkg::REG_IGNORE_CHAR_C:  ign_chars[2] = data;
      rlrb_pkg::REG_IGNORE_CHAR_D:  ign_chars[3] = data;
      default: ;
    endcase
  endtask

  task automatic set_ring_config(input logic [7:0] en, input logic [7:0] a,
                                 input logic [7:0] b, input logic [7:0] c,
                                 input logic [7:0] d);
    hold_until_drained();
    write_reg(rlrb_pkg::REG_RECEIVE_ENABLE, en);
    write_reg(rlrb_pkg::REG_IGNORE_CHAR_A, a);
    write_reg(rlrb_pkg::REG_IGNORE_CHAR_B, b);
    write_reg(rlrb_pkg::REG_IGNORE_CHAR_C, c);
    write_reg(rlrb_pkg::REG_IGNORE_CHAR_D, d);
  endtask

  // Mostly whole lines with random content, then reads; the rest is noise.
  task automatic random_phase(input int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 80) : $urandom_range(0, 12);
        repeat (len) send_item(ACT_BYTE, pick_byte(), 1'b0, NO_TYPED);
        send_item(ACT_BYTE, rlrb_pkg::NEWLINE_CHAR, 1'b0, NO_TYPED);
        sent += len + 1;
        if ($urandom_range(0, 3) != 0) begin
          send_item(ACT_READ, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
          sent++;
        end
      end else if (r < 85) begin
        send_item(ACT_READ, 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
        sent++;
      end else begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
        sent++;
      end
      if ($urandom_range(0, 49) == 0) hold_until_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (rx_results_q.size() == 0) begin
          $display("%0t: unexpected result: ignored_char %02h line_found %0b",
                   $time, ignored_char, line_found);
          $display("%0t: unexpected result: line_byte %02h last %0b",
                   $time, line_byte, last);
          mismatch_count++;
        end else begin
          head_res = rx_results_q.pop_front();
          if (ignored_char !== head_res.ignored_char) begin
            $display("%0t: ignored_char expected %02h, got %02h",
                     $time, head_res.ignored_char, ignored_char);
            mismatch_count++;
          end
          if (line_found !== head_res.line_found) begin
            $display("%0t: line_found expected %0b, got %0b",
                     $time, head_res.line_found, line_found);
            mismatch_count++;
          end
          if (line_byte !== head_res.line_byte) begin
            $display("%0t: line_byte expected %02h, got %02h",
                     $time, head_res.line_byte, line_byte);
            mismatch_count++;
          end
          if (last !== head_res.last) begin
            $display("%0t: last expected %0b, got %0b", $time, head_res.last, last);
            mismatch_count++;
          end
        end
      end
      pop <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    foreach (ring_mem[i]) ring_mem[i] = 8'h00;
    foreach (ign_chars[i]) ign_chars[i] = 8'h00;
    wr_ptr     = '0;
    head_ptr   = '0;
    nl_ptr     = '0;
    nl_pending = 1'b0;
    rx_en      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_REG: begin
          hold_until_drained();
          write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
        end
        ROW_BYTE: send_item(ACT_BYTE, DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        default:  send_item(ACT_READ, DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].res);
      endcase
    end

    set_ring_config(8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    random_phase(25);

    // long stretch with both sides running flat out
    set_ring_config(8'hFF, 8'($urandom_range(1, 255)), 8'h20, 8'h00,
                    8'($urandom_range(1, 255)));
    idle_on = 1'b0;
    random_phase(25);
    idle_on = 1'b1;

    // newline itself ignored: no new line can become pending
    set_ring_config(8'h01, rlrb_pkg::NEWLINE_CHAR, 8'hFF, 8'h00, 8'h80);
    random_phase(10);

    // reception off with upper data bits set
    set_ring_config(8'hFE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_phase(10);

    set_ring_config(8'h01, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_phase(25);

    hold_until_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
